@@ sv/square_wave_sound_channel_core_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef SQUARE_WAVE_SOUND_CHANNEL_CORE_MACROS_SVH
`define SQUARE_WAVE_SOUND_CHANNEL_CORE_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define SQC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is active.
`define SQC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sqc_pkg.sv @@
package sqc_pkg;

    typedef logic [2:0]        mode_t;
    typedef logic [1:0]        reg_index_t;
    typedef logic [7:0]        byte_t;
    typedef logic signed [4:0] sample_t;

    // Item kinds
    localparam mode_t MODE_WRITE    = 3'd0;
    localparam mode_t MODE_READ     = 3'd1;
    localparam mode_t MODE_TICK     = 3'd2;
    localparam mode_t MODE_ENVELOPE = 3'd3;
    localparam mode_t MODE_LENGTH   = 3'd4;

    // Channel registers
    localparam reg_index_t REG_DUTY_LEN  = 2'd0;
    localparam reg_index_t REG_ENVELOPE  = 2'd1;
    localparam reg_index_t REG_FREQ_LO   = 2'd2;
    localparam reg_index_t REG_FREQ_HI   = 2'd3;

    // Configuration register word index
    localparam logic CFG_MASTER_ENABLE = 1'b0;

    // Misc constants
    localparam logic [6:0]  LENGTH_FULL    = 7'd64;
    localparam logic [3:0]  VOLUME_MAX     = 4'd15;
    localparam logic [3:0]  ENV_RELOAD_MAX = 4'd8;
    localparam logic [13:0] PERIOD_RESET   = 14'd8192;
    localparam byte_t       READ_IDLE      = 8'hFF;

    // Duty waveforms, one bit per step, set where the sign is positive
    localparam logic [3:0][7:0] DUTY_POSITIVE = '{
        8'b0111_1110,   // duty 3
        8'b1110_0001,   // duty 2
        8'b1000_0001,   // duty 1
        8'b1000_0000    // duty 0
    };

    // Input item held in the input register
    typedef struct packed {
        mode_t      mode;
        reg_index_t reg_index;
        byte_t      write_data;
    } item_t;

    // Period reload: (2048 - frequency) * 4
    function automatic logic [13:0] period_reload(input logic [10:0] freq);
        logic [11:0] diff;
        begin
            diff = 12'd2048 - {1'b0, freq};
            return {diff, 2'b00};
        end
    endfunction

    // Envelope reload: period, or 8 when the period is 0
    function automatic logic [3:0] envelope_reload(input logic [2:0] period);
        begin
            return (period == 3'd0) ? ENV_RELOAD_MAX : {1'b0, period};
        end
    endfunction

endpackage

@@ sv/sqc_in_if.sv @@
interface sqc_in_if;
    import sqc_pkg::*;

    logic       valid;
    logic       ready;
    mode_t      mode;
    reg_index_t reg_index;
    byte_t      write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input reg_index, input write_data,
                    output ready);
endinterface

@@ sv/sqc_out_if.sv @@
interface sqc_out_if;
    import sqc_pkg::*;

    logic    valid;
    logic    ready;
    byte_t   read_data;
    sample_t sample;

    modport source (output valid, output read_data, output sample, input ready);
    modport sink   (input valid, input read_data, input sample, output ready);
endinterface

@@ sv/square_wave_sound_channel_core.sv @@
// Channel   | Dir | Payload                          | Transfer when
// ----------+-----+----------------------------------+------------------------
// in_ch     | in  | mode, reg_index, write_data      | valid && ready
// out_ch    | out | read_data, sample                | valid && ready
// APB       | in  | master_enable at word address 0  | psel && penable && pwrite
//
// Each item passes an input register and a result register, one item per
// cycle sustained while out_ch is not stalled; all channel state updates in the
// single cycle that moves an item from the input to the result register.
// rst_n clears all control state at once; there is no clearing pass.
// A stalled result holds in the result register while one more item waits
// in the input register; in_ch.ready drops only when both are full.
module square_wave_sound_channel_core (
    input  logic              clk,
    input  logic              rst_n,
    sqc_in_if.sink            in_ch,
    sqc_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import sqc_pkg::*;

    // Pipeline control
    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    byte_t   read_data_reg;
    sample_t sample_reg;
    logic    advance;

    // Configuration
    logic master_enable_reg;

    // Channel state
    logic [13:0] period_timer_reg,     period_timer_next;
    logic [2:0]  wave_position_reg,    wave_position_next;
    logic        channel_on_reg,       channel_on_next;
    logic [6:0]  length_count_reg,     length_count_next;
    logic        length_enable_reg,    length_enable_next;
    logic [1:0]  duty_select_reg,      duty_select_next;
    logic [2:0]  envelope_period_reg,  envelope_period_next;
    logic        envelope_up_reg,      envelope_up_next;
    logic [3:0]  start_volume_reg,     start_volume_next;
    logic [3:0]  volume_reg,           volume_next;
    logic [3:0]  envelope_timer_reg,   envelope_timer_next;
    logic        envelope_running_reg, envelope_running_next;
    logic [10:0] tone_frequency_reg,   tone_frequency_next;
    sample_t     last_sample_reg,      last_sample_next;
    byte_t       read_data_next;

    logic [10:0] freq_written;
    logic [3:0]  volume_stepped;
    logic        write_allowed;

    // APB: always ready, one register at word 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_MASTER_ENABLE) ? {31'd0, master_enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_enable_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == CFG_MASTER_ENABLE)
        begin
            master_enable_reg <= pwdata[0];
        end
    end

    // Handshake: input register feeds the result register
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.read_data = read_data_reg;
    assign out_ch.sample    = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg <= '{mode: in_ch.mode, reg_index: in_ch.reg_index,
                          write_data: in_ch.write_data};
        end
        if (advance)
        begin
            read_data_reg <= read_data_next;
            sample_reg    <= last_sample_next;
        end
    end

    // Item processing
    assign write_allowed = master_enable_reg || (item_reg.reg_index == REG_DUTY_LEN);
    assign freq_written  = {item_reg.write_data[2:0], tone_frequency_reg[7:0]};

    always_comb
    begin
        period_timer_next     = period_timer_reg;
        wave_position_next    = wave_position_reg;
        channel_on_next       = channel_on_reg;
        length_count_next     = length_count_reg;
        length_enable_next    = length_enable_reg;
        duty_select_next      = duty_select_reg;
        envelope_period_next  = envelope_period_reg;
        envelope_up_next      = envelope_up_reg;
        start_volume_next     = start_volume_reg;
        volume_next           = volume_reg;
        envelope_timer_next   = envelope_timer_reg;
        envelope_running_next = envelope_running_reg;
        tone_frequency_next   = tone_frequency_reg;
        last_sample_next      = last_sample_reg;
        read_data_next        = READ_IDLE;
        volume_stepped        = volume_reg;

        unique case (item_reg.mode)
            MODE_WRITE:
            begin
                if (write_allowed)
                begin
                    unique case (item_reg.reg_index)
                        REG_DUTY_LEN:
                        begin
                            length_count_next = LENGTH_FULL - {1'b0, item_reg.write_data[5:0]};
                            duty_select_next  = item_reg.write_data[7:6];
                        end
                        REG_ENVELOPE:
                        begin
                            envelope_period_next = item_reg.write_data[2:0];
                            envelope_up_next     = item_reg.write_data[3];
                            start_volume_next    = item_reg.write_data[7:4];
                        end
                        REG_FREQ_LO:
                        begin
                            tone_frequency_next = {tone_frequency_reg[10:8],
                                                   item_reg.write_data};
                        end
                        default:
                        begin
                            tone_frequency_next = freq_written;
                            length_enable_next  = item_reg.write_data[6];
                            // trigger
                            if (item_reg.write_data[7])
                            begin
                                channel_on_next = 1'b1;
                                if (length_count_reg == 7'd0)
                                begin
                                    length_count_next = LENGTH_FULL;
                                end
                                period_timer_next     = period_reload(freq_written);
                                envelope_timer_next   = envelope_reload(envelope_period_reg);
                                envelope_running_next = 1'b1;
                                volume_next           = start_volume_reg;
                            end
                        end
                    endcase
                end
            end
            MODE_READ:
            begin
                unique case (item_reg.reg_index)
                    REG_DUTY_LEN: read_data_next = {duty_select_reg, 6'h3F};
                    REG_ENVELOPE: read_data_next = {start_volume_reg, envelope_up_reg,
                                                    envelope_period_reg};
                    REG_FREQ_LO:  read_data_next = READ_IDLE;
                    default:      read_data_next = {1'b1, length_enable_reg, 6'h3F};
                endcase
            end
            MODE_TICK:
            begin
                if (period_timer_reg <= 14'd1)
                begin
                    period_timer_next  = period_reload(tone_frequency_reg);
                    wave_position_next = wave_position_reg + 3'd1;
                end
                else
                begin
                    period_timer_next = period_timer_reg - 14'd1;
                end
                // latch duty sign times volume, or zero while the channel is off
                if (!channel_on_reg)
                begin
                    last_sample_next = 5'sd0;
                end
                else if (DUTY_POSITIVE[duty_select_reg][wave_position_next])
                begin
                    last_sample_next = {1'b0, volume_reg};
                end
                else
                begin
                    last_sample_next = 5'd0 - {1'b0, volume_reg};
                end
            end
            MODE_ENVELOPE:
            begin
                if (envelope_timer_reg > 4'd1)
                begin
                    envelope_timer_next = envelope_timer_reg - 4'd1;
                end
                else
                begin
                    envelope_timer_next = envelope_reload(envelope_period_reg);
                    if (envelope_running_reg && envelope_period_reg != 3'd0)
                    begin
                        if (envelope_up_reg)
                        begin
                            if (volume_reg < VOLUME_MAX)
                            begin
                                volume_stepped = volume_reg + 4'd1;
                            end
                        end
                        else if (volume_reg > 4'd0)
                        begin
                            volume_stepped = volume_reg - 4'd1;
                        end
                        volume_next = volume_stepped;
                        if (volume_stepped == 4'd0 || volume_stepped == VOLUME_MAX)
                        begin
                            envelope_running_next = 1'b0;
                        end
                    end
                end
            end
            MODE_LENGTH:
            begin
                if (length_count_reg != 7'd0 && length_enable_reg)
                begin
                    length_count_next = length_count_reg - 7'd1;
                    if (length_count_reg == 7'd1)
                    begin
                        channel_on_next = 1'b0;
                    end
                end
            end
            default:
            begin
                read_data_next = READ_IDLE;
            end
        endcase
    end

    // Channel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_timer_reg     <= PERIOD_RESET;
            wave_position_reg    <= 3'd0;
            channel_on_reg       <= 1'b0;
            length_count_reg     <= 7'd0;
            length_enable_reg    <= 1'b0;
            duty_select_reg      <= 2'd0;
            envelope_period_reg  <= 3'd0;
            envelope_up_reg      <= 1'b0;
            start_volume_reg     <= 4'd0;
            volume_reg           <= 4'd0;
            envelope_timer_reg   <= ENV_RELOAD_MAX;
            envelope_running_reg <= 1'b0;
            tone_frequency_reg   <= 11'd0;
            last_sample_reg      <= 5'sd0;
        end
        else if (advance)
        begin
            period_timer_reg     <= period_timer_next;
            wave_position_reg    <= wave_position_next;
            channel_on_reg       <= channel_on_next;
            length_count_reg     <= length_count_next;
            length_enable_reg    <= length_enable_next;
            duty_select_reg      <= duty_select_next;
            envelope_period_reg  <= envelope_period_next;
            envelope_up_reg      <= envelope_up_next;
            start_volume_reg     <= start_volume_next;
            volume_reg           <= volume_next;
            envelope_timer_reg   <= envelope_timer_next;
            envelope_running_reg <= envelope_running_next;
            tone_frequency_reg   <= tone_frequency_next;
            last_sample_reg      <= last_sample_next;
        end
    end

endmodule

@@ sv/sqc_checker.sv @@
`include "square_wave_sound_channel_core_macros.svh"

module sqc_assertions (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [7:0]        read_data,
    input logic signed [4:0] sample
);
    // Items accepted whose results are not yet taken
    logic [1:0]  pending_reg;
    logic        in_xfer;
    logic        out_xfer;
    logic        out_stall;
    logic [12:0] result_bits;

    assign in_xfer     = in_valid && in_ready;
    assign out_xfer    = out_valid && out_ready;
    assign out_stall   = out_valid && !out_ready;
    assign result_bits = {read_data, sample};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    `SQC_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(result_bits), "result changed")
    `SQC_ASSERT(a_no_phantom, out_valid |-> pending_reg != 2'd0, "result with no item")
    `SQC_ASSERT(a_capacity, pending_reg == 2'd2 && out_stall |-> !in_ready, "taken when full")
    `SQC_ASSERT(a_sample_range, out_valid |-> sample != 5'sb10000, "sample out of range")
    `SQC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result shown during reset")

endmodule

bind square_wave_sound_channel_core sqc_assertions u_sqc_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .read_data (out_ch.read_data),
    .sample    (out_ch.sample)
);
